// ----- src/can_multiframe_reassembler_unit_defines.svh -----
// ----------------------------------------------------------------------------
// CAN multiframe reassembler: assertion macros
// Macros for the concurrent checks of the reassembler controller.
// ----------------------------------------------------------------------------
`ifndef CAN_MULTIFRAME_REASSEMBLER_UNIT_DEFINES_SVH
`define CAN_MULTIFRAME_REASSEMBLER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/can_mfr_pkg.sv -----
// ----------------------------------------------------------------------------
// CAN multiframe reassembler package
// Request, result and command types and the fixed codes of the reassembler.
// ----------------------------------------------------------------------------
package can_mfr_pkg;

    localparam int BYTES_PER_FRAME = 6;
    localparam int MAX_SLOTS       = 4;

    localparam logic       REQ_FRAME = 1'b0;
    localparam logic       REQ_ARM   = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_FNUM    = 2'd1;
    localparam logic [1:0] ERR_OVERRUN = 2'd2;

    localparam logic [15:0] FIRST_FRAME = 16'd1;

    // Division by six as multiply by ceil(2^18 / 6) and shift; exact for 16 bits.
    localparam logic [33:0] DIV6_RECIP = 34'd43691;
    localparam int          DIV6_SHIFT = 18;

    typedef struct packed {
        logic                                 req_type;
        logic [10:0]                          can_id;
        logic [1:0]                           slot_select;
        logic [15:0]                          object_length;
        logic [3:0]                           dlc;
        logic [15:0]                          frame_number;
        logic [BYTES_PER_FRAME-1:0][7:0]      payload;
    } t_req;

    typedef struct packed {
        logic                                 slot_hit;
        logic [1:0]                           slot_index;
        logic [15:0]                          write_offset;
        logic [2:0]                           write_count;
        logic [BYTES_PER_FRAME-1:0][7:0]      store;
        logic [1:0]                           slot_state;
        logic [1:0]                           error_kind;
    } t_rsp;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } t_ctrl_cmd;

endpackage

// ----- src/can_mfr_if.sv -----
// ----------------------------------------------------------------------------
// CAN multiframe reassembler channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface can_mfr_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [10:0] can_id;
    logic [1:0]  slot_select;
    logic [15:0] object_length;
    logic [3:0]  dlc;
    logic [15:0] frame_number;
    logic [7:0]  payload_0;
    logic [7:0]  payload_1;
    logic [7:0]  payload_2;
    logic [7:0]  payload_3;
    logic [7:0]  payload_4;
    logic [7:0]  payload_5;

    modport source (
        output valid, req_type, can_id, slot_select, object_length, dlc, frame_number,
               payload_0, payload_1, payload_2, payload_3, payload_4, payload_5,
        input  ready
    );

    modport sink (
        input  valid, req_type, can_id, slot_select, object_length, dlc, frame_number,
               payload_0, payload_1, payload_2, payload_3, payload_4, payload_5,
        output ready
    );
endinterface

interface can_mfr_rsp_if;
    logic        valid;
    logic        ready;
    logic        slot_hit;
    logic [1:0]  slot_index;
    logic [15:0] write_offset;
    logic [2:0]  write_count;
    logic [7:0]  store_0;
    logic [7:0]  store_1;
    logic [7:0]  store_2;
    logic [7:0]  store_3;
    logic [7:0]  store_4;
    logic [7:0]  store_5;
    logic [1:0]  slot_state;
    logic [1:0]  error_kind;

    modport source (
        output valid, slot_hit, slot_index, write_offset, write_count,
               store_0, store_1, store_2, store_3, store_4, store_5, slot_state, error_kind,
        input  ready
    );

    modport sink (
        input  valid, slot_hit, slot_index, write_offset, write_count,
               store_0, store_1, store_2, store_3, store_4, store_5, slot_state, error_kind,
        output ready
    );
endinterface

// ----- src/can_multiframe_reassembler_unit.sv -----
// A new item can be taken in the execute step, as the last one commits; slot
// lookup with the offset-to-frame multiply is registered, and the slot
// read-modify-write follows in the execute step.
// A result waiting at the output holds the next item in its execute step until taken.
// Reset is synchronous and active low; it empties the slot table at once.
// ----------------------------------------------------------------------------
// CAN multiframe reassembler
// Tracks receive slots and reports where the payload of each CAN frame goes.
// ----------------------------------------------------------------------------
module can_multiframe_reassembler_unit #(
    parameter int SLOT_COUNT = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    can_mfr_req_if.sink   i_req,
    can_mfr_rsp_if.source o_rsp
);
    import can_mfr_pkg::*;

    t_ctrl_cmd w_cmd;
    t_req      w_req;
    t_rsp      w_rsp;

    assign w_req.req_type      = i_req.req_type;
    assign w_req.can_id        = i_req.can_id;
    assign w_req.slot_select   = i_req.slot_select;
    assign w_req.object_length = i_req.object_length;
    assign w_req.dlc           = i_req.dlc;
    assign w_req.frame_number  = i_req.frame_number;
    assign w_req.payload[0]    = i_req.payload_0;
    assign w_req.payload[1]    = i_req.payload_1;
    assign w_req.payload[2]    = i_req.payload_2;
    assign w_req.payload[3]    = i_req.payload_3;
    assign w_req.payload[4]    = i_req.payload_4;
    assign w_req.payload[5]    = i_req.payload_5;

    can_mfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd)
    );

    can_mfr_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_rsp.slot_hit     = w_rsp.slot_hit;
    assign o_rsp.slot_index   = w_rsp.slot_index;
    assign o_rsp.write_offset = w_rsp.write_offset;
    assign o_rsp.write_count  = w_rsp.write_count;
    assign o_rsp.store_0      = w_rsp.store[0];
    assign o_rsp.store_1      = w_rsp.store[1];
    assign o_rsp.store_2      = w_rsp.store[2];
    assign o_rsp.store_3      = w_rsp.store[3];
    assign o_rsp.store_4      = w_rsp.store[4];
    assign o_rsp.store_5      = w_rsp.store[5];
    assign o_rsp.slot_state   = w_rsp.slot_state;
    assign o_rsp.error_kind   = w_rsp.error_kind;

endmodule

// ----- src/can_mfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// CAN multiframe reassembler controller
// Sequences capture, slot lookup and commit of one item, and owns result valid.
// ----------------------------------------------------------------------------
`include "can_multiframe_reassembler_unit_defines.svh"

module can_mfr_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output can_mfr_pkg::t_ctrl_cmd o_cmd
);
    import can_mfr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;
    logic       w_accept;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) || ((r_state == S_EXEC) && w_out_free);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.capture = w_accept;
        o_cmd.lookup  = (r_state == S_LOOK);
        o_cmd.commit  = (r_state == S_EXEC) && w_out_free;
        n_state       = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state = w_accept ? S_LOOK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `CMR_ASSERT_NEXT(a_look_then_exec, r_state == S_LOOK, r_state == S_EXEC, "lookup not followed by execute")
    `CMR_ASSERT_NEXT(a_commit_shows_result, o_cmd.commit, r_out_valid, "committed result not presented")
    `CMR_ASSERT_NOW(a_ready_states, o_in_ready, r_state == S_IDLE || r_state == S_EXEC, "ready while looking up")
    `CMR_ASSERT_NOW(a_commit_needs_room, o_cmd.commit, !r_out_valid || i_out_ready, "commit overwrote a waiting result")

endmodule

// ----- src/can_mfr_datapath.sv -----
// ----------------------------------------------------------------------------
// CAN multiframe reassembler datapath
// Holds the slot table, matches frame IDs and updates offset and status.
// ----------------------------------------------------------------------------
module can_mfr_datapath #(
    parameter int SLOT_COUNT = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  can_mfr_pkg::t_ctrl_cmd i_cmd,
    input  can_mfr_pkg::t_req      i_req,
    output can_mfr_pkg::t_rsp      o_rsp
);
    import can_mfr_pkg::*;

    // Only slots that the two-bit select can reach are ever armed.
    localparam int NUM_SLOTS = (SLOT_COUNT < MAX_SLOTS) ? SLOT_COUNT : MAX_SLOTS;
    localparam int IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [NUM_SLOTS-1:0] r_valid;
    logic [10:0]          r_id     [NUM_SLOTS];
    logic [15:0]          r_len    [NUM_SLOTS];
    logic [15:0]          r_off    [NUM_SLOTS];
    logic [1:0]           r_status [NUM_SLOTS];

    t_req        r_req;
    t_rsp        r_rsp;
    logic        r_found;
    logic [IW-1:0] r_slot;
    logic [15:0] r_cur_off;
    logic [15:0] r_cur_len;
    logic [1:0]  r_cur_status;
    logic [15:0] r_expect;

    logic          w_found;
    logic [IW-1:0] w_idx;
    logic [15:0]   w_sel_off;
    logic [33:0]   w_prod;

    t_rsp          w_rsp;
    logic          w_wr_arm;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_idx;
    logic [15:0]   w_new_off;
    logic [1:0]    w_new_status;
    logic          w_restart;
    logic [2:0]    w_nbytes;
    logic [15:0]   w_start;
    logic [15:0]   w_room;
    logic [15:0]   w_end;
    logic          w_overrun;
    logic [2:0]    w_count;

    always_comb begin
        w_found = 1'b0;
        w_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_id[i] == r_req.can_id)) begin
                w_found = 1'b1;
                w_idx   = IW'(i);
            end
        end
    end

    assign w_sel_off = r_off[w_idx];
    assign w_prod    = {18'd0, w_sel_off} * DIV6_RECIP;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.lookup) begin
            r_found      <= w_found;
            r_slot       <= w_idx;
            r_cur_off    <= w_sel_off;
            r_cur_len    <= r_len[w_idx];
            r_cur_status <= r_status[w_idx];
            r_expect     <= w_prod[DIV6_SHIFT+15:DIV6_SHIFT] + 16'd1;
        end
        if (i_cmd.commit) begin
            r_rsp <= w_rsp;
        end
    end

    assign w_restart = (r_req.frame_number != r_expect);
    assign w_nbytes  = (r_req.dlc >= 4'd8) ? 3'(BYTES_PER_FRAME) :
                       (r_req.dlc > 4'd2)  ? 3'(r_req.dlc - 4'd2) : 3'd0;
    assign w_start   = w_restart ? 16'd0 : r_cur_off;
    assign w_room    = r_cur_len - w_start;
    assign w_overrun = {13'd0, w_nbytes} > w_room;
    assign w_count   = w_overrun ? w_room[2:0] : w_nbytes;
    assign w_end     = w_start + {13'd0, w_nbytes};

    always_comb begin
        w_rsp        = '0;
        w_wr_arm     = 1'b0;
        w_wr_en      = 1'b0;
        w_wr_idx     = r_slot;
        w_new_off    = 16'd0;
        w_new_status = ST_DONE;
        w_rsp.error_kind = ERR_NONE;
        if (r_req.req_type == REQ_ARM) begin
            w_rsp.slot_index = r_req.slot_select;
            w_wr_idx         = r_req.slot_select[IW-1:0];
            if (int'(r_req.slot_select) < SLOT_COUNT) begin
                w_rsp.slot_hit   = 1'b1;
                w_rsp.slot_state = ST_BUSY;
                w_wr_arm         = 1'b1;
            end
        end else if (r_found) begin
            w_rsp.slot_index = 2'(r_slot);
            if (r_cur_status != ST_BUSY) begin
                w_rsp.slot_state = r_cur_status;
            end else begin
                w_rsp.slot_hit = 1'b1;
                w_wr_en        = 1'b1;
                if (w_restart && (r_req.frame_number != FIRST_FRAME)) begin
                    w_new_status     = ST_ERROR;
                    w_rsp.slot_state = ST_ERROR;
                    w_rsp.error_kind = ERR_FNUM;
                end else begin
                    w_rsp.write_offset = w_start;
                    w_rsp.write_count  = w_count;
                    for (int k = 0; k < BYTES_PER_FRAME; k++) begin
                        if (3'(k) < w_count) begin
                            w_rsp.store[k] = r_req.payload[k];
                        end
                    end
                    if (w_overrun) begin
                        w_new_status     = ST_ERROR;
                        w_rsp.error_kind = ERR_OVERRUN;
                    end else if (w_end == r_cur_len) begin
                        w_new_status = ST_DONE;
                    end else begin
                        w_new_status = ST_BUSY;
                        w_new_off    = w_end;
                    end
                    w_rsp.slot_state = w_new_status;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.commit && w_wr_arm) begin
            r_valid[w_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_wr_arm) begin
            r_id[w_wr_idx]     <= r_req.can_id;
            r_len[w_wr_idx]    <= r_req.object_length;
            r_off[w_wr_idx]    <= 16'd0;
            r_status[w_wr_idx] <= ST_BUSY;
        end else if (i_cmd.commit && w_wr_en) begin
            r_off[w_wr_idx]    <= w_new_off;
            r_status[w_wr_idx] <= w_new_status;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAN multiframe reassembler testbench
// Drives arm requests and CAN frames into the reassembler and checks every
// result against a slot-table predictor kept in step with accepted items.
// Directed cases cover restarts, frame number errors, overruns, completion
// and duplicate IDs; random transfer sequences with noise follow. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    import can_mfr_pkg::*;

    localparam int SLOT_CNT    = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    can_mfr_req_if req_ch ();
    can_mfr_rsp_if rsp_ch ();

    can_multiframe_reassembler_unit #(
        .SLOT_COUNT(SLOT_CNT)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    t_req request_q[$];
    t_rsp placement_q[$];

    logic        slot_used [SLOT_CNT];
    logic [10:0] slot_id   [SLOT_CNT];
    logic [15:0] slot_len  [SLOT_CNT];
    logic [15:0] slot_off  [SLOT_CNT];
    logic [1:0]  slot_st   [SLOT_CNT];

    int sent_cnt = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    t_req cur;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_rsp reassemble(t_req rq);
        t_rsp r;
        int hit;
        int nb;
        logic [15:0] due;
        logic [3:0] d;
        bit stop;
        r = '0;
        hit = -1;
        stop = 1'b0;
        if (rq.req_type == REQ_ARM) begin
            r.slot_index = rq.slot_select;
            if (int'(rq.slot_select) < SLOT_CNT) begin
                slot_used[rq.slot_select] = 1'b1;
                slot_id[rq.slot_select] = rq.can_id;
                slot_len[rq.slot_select] = rq.object_length;
                slot_off[rq.slot_select] = '0;
                slot_st[rq.slot_select] = ST_BUSY;
                r.slot_hit = 1'b1;
                r.slot_state = ST_BUSY;
            end
            return r;
        end
        for (int i = SLOT_CNT - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_id[i] == rq.can_id) hit = i;
        end
        if (hit < 0) return r;
        r.slot_index = hit[1:0];
        if (slot_st[hit] != ST_BUSY) begin
            r.slot_state = slot_st[hit];
            return r;
        end
        r.slot_hit = 1'b1;
        due = 16'(slot_off[hit] / BYTES_PER_FRAME + 1);
        if (rq.frame_number != due) begin
            slot_off[hit] = '0;
            if (rq.frame_number != FIRST_FRAME) begin
                slot_st[hit] = ST_ERROR;
                r.slot_state = ST_ERROR;
                r.error_kind = ERR_FNUM;
                return r;
            end
        end
        d = (rq.dlc > 4'd8) ? 4'd8 : rq.dlc;
        nb = (d > 4'd2) ? int'(d) - 2 : 0;
        r.write_offset = slot_off[hit];
        for (int k = 0; k < nb && !stop; k++) begin
            if (slot_off[hit] < slot_len[hit]) begin
                r.store[k] = rq.payload[k];
                slot_off[hit] = slot_off[hit] + 16'd1;
                r.write_count = r.write_count + 3'd1;
            end else begin
                slot_st[hit] = ST_ERROR;
                slot_off[hit] = '0;
                r.slot_state = ST_ERROR;
                r.error_kind = ERR_OVERRUN;
                stop = 1'b1;
            end
        end
        if (!stop) begin
            if (slot_off[hit] == slot_len[hit]) begin
                slot_st[hit] = ST_DONE;
                slot_off[hit] = '0;
            end else begin
                slot_st[hit] = ST_BUSY;
            end
            r.slot_state = slot_st[hit];
        end
        return r;
    endfunction

    function automatic logic [47:0] rnd_bytes();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[47:0];
    endfunction

    function automatic t_req rnd_req();
        logic [127:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom()};
        return raw[$bits(t_req)-1:0];
    endfunction

    task automatic push_arm(input logic [1:0] sel, input logic [10:0] id,
                            input logic [15:0] len);
        t_req rq;
        rq = rnd_req();
        rq.req_type = REQ_ARM;
        rq.slot_select = sel;
        rq.can_id = id;
        rq.object_length = len;
        request_q.push_back(rq);
    endtask

    task automatic push_frame(input logic [10:0] id, input logic [3:0] dlc,
                              input logic [15:0] fnum, input logic [47:0] data);
        t_req rq;
        rq = rnd_req();
        rq.req_type = REQ_FRAME;
        rq.can_id = id;
        rq.dlc = dlc;
        rq.frame_number = fnum;
        rq.payload = data;
        request_q.push_back(rq);
    endtask

    task automatic note_failure(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%s", msg);
    endtask

    function automatic bit side_idles();
        if (sent_cnt >= 300 && sent_cnt < 450) return 1'b0;
        return $urandom_range(0, 99) < 24;
    endfunction

    // Request driver.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            for (int i = 0; i < SLOT_CNT; i++) begin
                slot_used[i] = 1'b0;
                slot_id[i] = '0;
                slot_len[i] = '0;
                slot_off[i] = '0;
                slot_st[i] = ST_DONE;
            end
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                placement_q.push_back(reassemble(cur));
                sent_cnt++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (request_q.size() > 0 && !side_idles()) begin
                    cur = request_q.pop_front();
                    req_ch.req_type <= cur.req_type;
                    req_ch.can_id <= cur.can_id;
                    req_ch.slot_select <= cur.slot_select;
                    req_ch.object_length <= cur.object_length;
                    req_ch.dlc <= cur.dlc;
                    req_ch.frame_number <= cur.frame_number;
                    req_ch.payload_0 <= cur.payload[0];
                    req_ch.payload_1 <= cur.payload[1];
                    req_ch.payload_2 <= cur.payload[2];
                    req_ch.payload_3 <= cur.payload[3];
                    req_ch.payload_4 <= cur.payload[4];
                    req_ch.payload_5 <= cur.payload[5];
                    req_ch.valid <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off, started once enough items have gone in.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && sent_cnt >= 600) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor.
    always @(posedge clk) begin
        t_rsp act;
        t_rsp exp;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                act.slot_hit = rsp_ch.slot_hit;
                act.slot_index = rsp_ch.slot_index;
                act.write_offset = rsp_ch.write_offset;
                act.write_count = rsp_ch.write_count;
                act.store[0] = rsp_ch.store_0;
                act.store[1] = rsp_ch.store_1;
                act.store[2] = rsp_ch.store_2;
                act.store[3] = rsp_ch.store_3;
                act.store[4] = rsp_ch.store_4;
                act.store[5] = rsp_ch.store_5;
                act.slot_state = rsp_ch.slot_state;
                act.error_kind = rsp_ch.error_kind;
                if (placement_q.size() == 0) begin
                    note_failure("Result item arrived with no expectation waiting.");
                end else begin
                    exp = placement_q.pop_front();
                    if (act !== exp) begin
                        note_failure($sformatf(
                            "Mismatch: exp hit=%0d slot=%0d off=%0d cnt=%0d st=%0d err=%0d data=%h",
                            exp.slot_hit, exp.slot_index, exp.write_offset, exp.write_count,
                            exp.slot_state, exp.error_kind, exp.store));
                        if (err_cnt <= 10) begin
                            $display(
                                "          got hit=%0d slot=%0d off=%0d cnt=%0d st=%0d err=%0d data=%h",
                                act.slot_hit, act.slot_index, act.write_offset, act.write_count,
                                act.slot_state, act.error_kind, act.store);
                        end
                    end
                end
            end
            rsp_ch.ready <= (hold_left == 0) && !side_idles();
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int slot;
        int len;
        int nfr;
        int left;
        int nbytes;
        int roll;
        int total;
        logic [10:0] id;
        logic [3:0] dlc;
        logic [15:0] fnum;

        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_FRAME;
        req_ch.can_id = '0;
        req_ch.slot_select = '0;
        req_ch.object_length = '0;
        req_ch.dlc = '0;
        req_ch.frame_number = '0;
        req_ch.payload_0 = '0;
        req_ch.payload_1 = '0;
        req_ch.payload_2 = '0;
        req_ch.payload_3 = '0;
        req_ch.payload_4 = '0;
        req_ch.payload_5 = '0;
        rsp_ch.ready = 1'b0;

        // A complete three-frame object, then frames that must be ignored.
        push_arm(2'd0, 11'h123, 16'd14);
        push_frame(11'h123, 4'd8, 16'd1, 48'h0);
        push_frame(11'h123, 4'd8, 16'd2, 48'hFFFF_FFFF_FFFF);
        push_frame(11'h123, 4'd4, 16'd3, rnd_bytes());
        push_frame(11'h123, 4'd8, 16'd1, rnd_bytes());
        push_frame(11'h456, 4'd8, 16'd1, rnd_bytes());
        // Oversized dlc, restart on frame one, short dlc, bad frame number.
        push_arm(2'd1, 11'h7FF, 16'hFFFF);
        push_frame(11'h7FF, 4'd15, 16'd1, rnd_bytes());
        push_frame(11'h7FF, 4'd8, 16'd1, rnd_bytes());
        push_frame(11'h7FF, 4'd2, 16'd2, rnd_bytes());
        push_frame(11'h7FF, 4'd1, 16'd2, rnd_bytes());
        push_frame(11'h7FF, 4'd8, 16'hFFFF, rnd_bytes());
        push_frame(11'h7FF, 4'd8, 16'd1, rnd_bytes());
        // Zero-length object completes on a frame without payload.
        push_arm(2'd2, 11'h000, 16'd0);
        push_frame(11'h000, 4'd0, 16'd1, rnd_bytes());
        // Overrun in the middle of a frame.
        push_arm(2'd3, 11'h055, 16'd3);
        push_frame(11'h055, 4'd8, 16'd1, rnd_bytes());
        // Duplicate IDs: the lower slot takes the frames.
        push_arm(2'd2, 11'h055, 16'd5);
        push_frame(11'h055, 4'd7, 16'd1, rnd_bytes());
        push_frame(11'h055, 4'd8, 16'd1, rnd_bytes());
        // Overrun before the first byte, and frame number zero.
        push_arm(2'd1, 11'h7FF, 16'd0);
        push_frame(11'h7FF, 4'd3, 16'd1, rnd_bytes());
        push_arm(2'd0, 11'h123, 16'd100);
        push_frame(11'h123, 4'd8, 16'd0, rnd_bytes());

        while (request_q.size() < 925) begin
            slot = $urandom_range(0, 3);
            id = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 3))
                                             : 11'($urandom_range(0, 2047));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 40);
            push_arm(2'(slot), id, 16'(len));
            nfr = (len + 5) / 6;
            if (nfr > 8) nfr = 8;
            if ($urandom_range(0, 5) == 0) nfr++;
            left = len;
            for (int f = 1; f <= nfr; f++) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    push_frame(11'($urandom_range(0, 2047)), 4'($urandom_range(0, 15)),
                               16'($urandom_range(0, 65535)), rnd_bytes());
                end
                fnum = 16'(f);
                if (roll >= 4 && roll < 8) fnum = 16'($urandom_range(0, 65535));
                else if (roll >= 8 && roll < 11) fnum = FIRST_FRAME;
                nbytes = (left > BYTES_PER_FRAME) ? BYTES_PER_FRAME : left;
                dlc = 4'(nbytes + 2);
                if ($urandom_range(0, 9) == 0) dlc = 4'($urandom_range(0, 15));
                push_frame(id, dlc, fnum, rnd_bytes());
                left = left - nbytes;
            end
        end
        total = request_q.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_cnt < total) @(posedge clk);
        while (placement_q.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+src
src/can_mfr_pkg.sv
src/can_mfr_if.sv
src/can_mfr_ctrl.sv
src/can_mfr_datapath.sv
src/can_multiframe_reassembler_unit.sv
dv/tb.sv
